// File: rtl/cbp_pkg.sv
package cbp_pkg;

    // Default geometry: signed Q11.4 coordinates and a Q1.16 curve parameter.
    localparam int COORD_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_POINT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABSOLUTE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STACK       = 3'd4;

    // Request kinds.
    localparam logic REQ_START = 1'b0;

endpackage

// File: rtl/cbp_if.sv
interface cbp_req_if
    import cbp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic        [TIME_BITS:0]    time_frac;
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [COORD_BITS-1:0] cur_z;

    modport source (output valid, req_type, time_frac, cur_x, cur_y, cur_z, input ready);
    modport sink   (input valid, req_type, time_frac, cur_x, cur_y, cur_z, output ready);
endinterface

interface cbp_rsp_if
    import cbp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// File: rtl/cubic_bezier_path_3d.sv
// Channel   Direction  Payload                                  Transfer when
// req       in         req_type, time_frac, cur_x/cur_y/cur_z   req.valid && req.ready
// rsp       out        pos_x, pos_y, pos_z                      rsp.valid && rsp.ready
// cfg       in         cfg_idx, cfg_data                        cfg_we
//
// A start request loads the nine curve point coordinates and then passes through
// S_FIN to the output register. For a step request all fourteen products go
// through one shift-add multiplier that retires one multiplier bit per cycle,
// with a load state before and a store state after each product.
// Reset clears the configuration but for stack mode, which it sets, and the latched
// start, the previous output and the curve points, so a step before any start has zero offset.
// A new request is taken as soon as the sequencer is idle, even while a result waits
// in the output register; a stalled output only holds the sequencer at its last cycle.
module cubic_bezier_path_3d
    import cbp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_idx,
    input  logic [3*COORD_BITS-1:0]   cfg_data,
    cbp_req_if.sink                   req,
    cbp_rsp_if.source                 rsp
);

    localparam int CB    = COORD_BITS;
    localparam int TB    = TIME_BITS;
    // Multiplier operand: a weight of up to 3 * 2^TB.
    localparam int MB    = TB + 2;
    // Accumulator: wide enough for t*t products and for a three-term curve sum.
    localparam int AW    = (2 * TB + 2 > TB + CB + 5) ? 2 * TB + 2 : TB + CB + 5;
    localparam int OW    = AW - TB;
    localparam int SW    = OW + 1;
    localparam int PW    = 3 * CB;
    localparam int CNT_W = $clog2(MB);

    localparam int CMAX_I = (1 << (CB - 1)) - 1;
    localparam logic signed [SW-1:0] SMAX = SW'(CMAX_I);
    localparam logic signed [SW-1:0] SMIN = SW'(-CMAX_I - 1);
    localparam logic [TB:0]   ONE_T  = {1'b1, {TB{1'b0}}};
    localparam logic [AW-1:0] HALF_A = {{(AW - TB){1'b0}}, 1'b1, {(TB - 1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [2:0] OP_TT  = 3'd0;
    localparam logic [2:0] OP_UU  = 3'd1;
    localparam logic [2:0] OP_W1  = 3'd2;
    localparam logic [2:0] OP_W2  = 3'd3;
    localparam logic [2:0] OP_W3  = 3'd4;
    localparam logic [2:0] OP_SUM = 3'd5;

    // Which curve point of an axis: first control, second control, end.
    localparam logic [1:0] J_B = 2'd0;
    localparam logic [1:0] J_C = 2'd1;
    localparam logic [1:0] J_D = 2'd2;

    localparam logic [1:0] AX_Z = 2'd2;

    function automatic logic signed [SW-1:0] sx(input logic signed [CB-1:0] v);
        sx = {{(SW - CB){v[CB-1]}}, v};
    endfunction

    function automatic logic signed [CB-1:0] sat_f(input logic signed [SW-1:0] v);
        if (v > SMAX)
        begin
            sat_f = SMAX[CB-1:0];
        end
        else if (v < SMIN)
        begin
            sat_f = SMIN[CB-1:0];
        end
        else
        begin
            sat_f = v[CB-1:0];
        end
    endfunction

    // Configuration registers.
    logic [PW-1:0] control_one_reg;
    logic [PW-1:0] control_two_reg;
    logic [PW-1:0] end_point_reg;
    logic          absolute_reg;
    logic          stack_reg;

    // Sequencer.
    logic [2:0]       state_reg;
    logic [2:0]       op_reg;
    logic [1:0]       axis_reg;
    logic [1:0]       j_reg;
    logic [3:0]       k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;

    // Curve state kept between requests.
    logic signed [CB-1:0] start_reg [3];
    logic signed [CB-1:0] prev_reg  [3];
    logic signed [CB-1:0] rel_reg   [9];

    // Per-request datapath.
    logic signed [CB-1:0] cur_reg [3];
    logic signed [CB-1:0] res_reg [3];
    logic signed [CB-1:0] pos_reg [3];
    logic [TB:0]          t_reg;
    logic [TB:0]          u_reg;
    logic [TB:0]          tt_reg;
    logic [TB:0]          uu_reg;
    logic [MB-1:0]        w1_reg;
    logic [MB-1:0]        w2_reg;
    logic [MB-1:0]        w3_reg;
    logic [AW-1:0]        md_reg;
    logic [MB-1:0]        mr_reg;
    logic [AW-1:0]        acc_reg;

    logic                 req_xfer;
    logic                 out_free;
    logic [TB:0]          t_in;
    logic [PW-1:0]        pt_word;
    logic signed [CB-1:0] pt_axis;
    logic signed [CB-1:0] prep_base;
    logic signed [CB-1:0] prep_val;
    logic signed [CB-1:0] start_drift;
    logic signed [SW-1:0] off_ext;
    logic signed [CB-1:0] sum_res;
    logic [TB:0]          r_val;
    logic [MB-1:0]        w_sel;
    logic [AW-1:0]        ld_md;
    logic [MB-1:0]        ld_mr;

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.pos_x = pos_reg[0];
    assign rsp.pos_y = pos_reg[1];
    assign rsp.pos_z = pos_reg[2];

    // A time fraction above 1.0 counts as 1.0.
    assign t_in = req.time_frac[TB] ? ONE_T : req.time_frac;

    // Loading the curve points at a start: one point coordinate per cycle, made
    // relative to the start position when the points are absolute.
    always_comb
    begin
        case (j_reg)
            J_B:     pt_word = control_one_reg;
            J_C:     pt_word = control_two_reg;
            default: pt_word = end_point_reg;
        endcase
    end

    assign pt_axis   = pt_word[axis_reg*CB +: CB];
    assign prep_base = absolute_reg ? cur_reg[axis_reg] : '0;
    assign prep_val  = sat_f(sx(pt_axis) - sx(prep_base));

    // In stack mode the start follows whatever moved the object since our last output.
    assign start_drift = sat_f(sx(start_reg[axis_reg]) + sx(cur_reg[axis_reg])
                               - sx(prev_reg[axis_reg]));

    // The accumulator was seeded with one half, so dropping the fraction bits rounds
    // half up; the arithmetic shift floors negative sums.
    assign off_ext = $signed({acc_reg[AW-1], acc_reg[AW-1:TB]});
    assign sum_res = sat_f(off_ext + sx(start_reg[axis_reg]));
    assign r_val   = acc_reg[TB +: TB + 1];

    always_comb
    begin
        case (j_reg)
            J_B:     w_sel = w1_reg;
            J_C:     w_sel = w2_reg;
            default: w_sel = w3_reg;
        endcase
    end

    // Operands for the next product.
    always_comb
    begin
        case (op_reg)
            OP_TT:
            begin
                ld_md = {{(AW - TB - 1){1'b0}}, t_reg};
                ld_mr = {1'b0, t_reg};
            end
            OP_UU:
            begin
                ld_md = {{(AW - TB - 1){1'b0}}, u_reg};
                ld_mr = {1'b0, u_reg};
            end
            OP_W1:
            begin
                ld_md = {{(AW - TB - 1){1'b0}}, t_reg};
                ld_mr = {1'b0, uu_reg};
            end
            OP_W2:
            begin
                ld_md = {{(AW - TB - 1){1'b0}}, u_reg};
                ld_mr = {1'b0, tt_reg};
            end
            OP_W3:
            begin
                ld_md = {{(AW - TB - 1){1'b0}}, t_reg};
                ld_mr = {1'b0, tt_reg};
            end
            default:
            begin
                ld_md = {{(AW - CB){rel_reg[k_reg][CB-1]}}, rel_reg[k_reg]};
                ld_mr = w_sel;
            end
        endcase
    end

    // Control state, configuration and the curve state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_one_reg <= '0;
            control_two_reg <= '0;
            end_point_reg   <= '0;
            absolute_reg    <= 1'b0;
            stack_reg       <= 1'b1;
            state_reg       <= S_IDLE;
            op_reg          <= OP_TT;
            axis_reg        <= '0;
            j_reg           <= J_B;
            k_reg           <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            start_reg       <= '{default: '0};
            prev_reg        <= '{default: '0};
            rel_reg         <= '{default: '0};
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_CONTROL_ONE: control_one_reg <= cfg_data;
                    REG_CONTROL_TWO: control_two_reg <= cfg_data;
                    REG_END_POINT:   end_point_reg   <= cfg_data;
                    REG_ABSOLUTE:    absolute_reg    <= cfg_data[0];
                    REG_STACK:       stack_reg       <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // The output register fills from the last sequencer cycle and empties
            // on a transfer.
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        axis_reg <= '0;
                        j_reg    <= J_B;
                        k_reg    <= '0;
                        op_reg   <= OP_TT;
                        if (req.req_type == REQ_START)
                        begin
                            start_reg <= '{req.cur_x, req.cur_y, req.cur_z};
                            prev_reg  <= '{req.cur_x, req.cur_y, req.cur_z};
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_PREP:
                begin
                    rel_reg[k_reg] <= prep_val;
                    k_reg          <= k_reg + 4'd1;
                    if (j_reg == J_D)
                    begin
                        j_reg <= J_B;
                        if (axis_reg == AX_Z)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                    if (op_reg == OP_SUM && j_reg == J_B && stack_reg)
                    begin
                        start_reg[axis_reg] <= start_drift;
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MB - 1))
                    begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    if (op_reg != OP_SUM)
                    begin
                        op_reg    <= op_reg + 3'd1;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        k_reg <= k_reg + 4'd1;
                        if (j_reg == J_D)
                        begin
                            j_reg <= J_B;
                            if (stack_reg)
                            begin
                                prev_reg[axis_reg] <= sum_res;
                            end
                            if (axis_reg == AX_Z)
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                axis_reg  <= axis_reg + 2'd1;
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath payload: the shift-add multiplier, the weights and the results.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    cur_reg <= '{req.cur_x, req.cur_y, req.cur_z};
                    t_reg   <= t_in;
                    u_reg   <= ONE_T - t_in;
                    if (req.req_type == REQ_START)
                    begin
                        res_reg <= '{req.cur_x, req.cur_y, req.cur_z};
                    end
                end
            end
            S_LOAD:
            begin
                md_reg <= ld_md;
                mr_reg <= ld_mr;
                // Each square, each weight and each axis sum starts from one half for rounding.
                if (op_reg != OP_SUM || j_reg == J_B)
                begin
                    acc_reg <= HALF_A;
                end
            end
            S_MUL:
            begin
                if (mr_reg[0])
                begin
                    acc_reg <= acc_reg + md_reg;
                end
                md_reg <= {md_reg[AW-2:0], 1'b0};
                mr_reg <= {1'b0, mr_reg[MB-1:1]};
            end
            S_STORE:
            begin
                case (op_reg)
                    OP_TT: tt_reg <= r_val;
                    OP_UU: uu_reg <= r_val;
                    OP_W1: w1_reg <= {1'b0, r_val} + {r_val, 1'b0};
                    OP_W2: w2_reg <= {1'b0, r_val} + {r_val, 1'b0};
                    OP_W3: w3_reg <= {1'b0, r_val};
                    default:
                    begin
                        if (j_reg == J_D)
                        begin
                            // Plain mode leaves z where the object already is.
                            if (!stack_reg && axis_reg == AX_Z)
                            begin
                                res_reg[axis_reg] <= cur_reg[axis_reg];
                            end
                            else
                            begin
                                res_reg[axis_reg] <= sum_res;
                            end
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    pos_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The bit counter never runs past the multiplier operand.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg < CNT_W'(MB)))
        else $error("multiplier bit counter out of range");

    // The point index agrees with the axis and point selectors wherever a curve point is loaded or read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP || (state_reg == S_LOAD && op_reg == OP_SUM))
        |-> (k_reg == 4'(axis_reg) * 4'd3 + 4'(j_reg)))
        else $error("curve point index out of step with axis and point");

    // A result is held back, not dropped, while the output register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !rsp.ready) |=> (state_reg == S_FIN))
        else $error("result left the sequencer while the output was stalled");

    // A start transfer goes straight to loading the curve points.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && req.req_type == REQ_START) |=> (state_reg == S_PREP && k_reg == 4'd0))
        else $error("start request did not begin the point load");

endmodule

// File: verif/cubic_bezier_path_3d_tb.sv
// Self-checking bench for the 3D cubic Bezier path block.
//
// Requests go in on one valid/ready channel and positions come back on another,
// one position per request.  Each accepted request also runs through a path
// predictor kept in this module.  The predictor holds its own copy of the curve
// registers, the latched start, the previous output and the relative curve
// points.  The expected position is queued and compared with the next position
// transfer.
//
// The run has two parts.  The first is a short opening plan of register writes
// and requests.  It covers a step before any start, curve points at both
// extremes, the end of the curve, a time fraction past one, saturation in both
// directions, absolute mode, plain mode and writes to unused register indexes.
// The second part is eight random phases.  Each phase writes every register and
// then mostly sends well-formed paths: a start, then steps that sweep t from
// zero to one while the object follows the last output.  The rest is noise.
module cubic_bezier_path_3d_tb
    import cbp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_BITS_DEF;
    localparam int TW = TIME_BITS_DEF;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    // The slowest correct run is about 600 requests, and the limit leaves several
    // times the time that it needs, sender gaps and receiver stalls included.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // This gives a step time to finish in the block, so a stray extra position
    // after the last expected one is caught.
    localparam int LATE_CYCLES  = 300;
    localparam int SHOWN_ERRORS = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_QUOTA   = 66;

    // Fixed-point constants.  ONE is t = 1.0 in Q1.16, and T_WRAP is the largest
    // time_frac that the 17-bit field can carry.
    localparam int     ONE      = 1 << TW;
    localparam int     T_WRAP   = (1 << (TW + 1)) - 1;
    localparam longint HALF     = longint'(1) << (TW - 1);
    localparam int     COORD_HI = (1 << (CW - 1)) - 1;
    localparam int     COORD_LO = -(1 << (CW - 1));

    localparam logic REQ_STEP = ~REQ_START;

    // Register indexes past the end of the map.  A write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_STACK + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    // Curve points with every axis at the top or the bottom of the range.
    localparam logic [3*CW-1:0] PTS_MAX = {3{1'b0, {(CW-1){1'b1}}}};
    localparam logic [3*CW-1:0] PTS_MIN = {3{1'b1, {(CW-1){1'b0}}}};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } pos_t;

    // One row of stimulus.  A row is either a register write or a request.  A
    // request row may carry a typed-in position.  Without one, the predictor
    // supplies the expected position.
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [3*CW-1:0]      data;
        logic                 rtype;
        logic [TW:0]          tf;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 typed;
        pos_t                 want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [3*CW-1:0] cfg_data;

    cbp_req_if #(.COORD_BITS(CW), .TIME_BITS(TW)) req_ch ();
    cbp_rsp_if #(.COORD_BITS(CW)) rsp_ch ();

    cubic_bezier_path_3d #(
        .COORD_BITS(CW),
        .TIME_BITS (TW)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state.  It mirrors the registers and the path state of the block.
    logic [3*CW-1:0] reg_one;
    logic [3*CW-1:0] reg_two;
    logic [3*CW-1:0] reg_end;
    logic            abs_on;
    logic            stack_on;
    longint          anchor_pos [3];
    longint          last_out [3];
    longint          curve_pts [9];

    // This is the last predicted position.  Random paths use it so that the object
    // follows the curve.
    pos_t last_result;

    pos_t expected_positions [$];

    // Idle rates, in percent per cycle, for the phase that is running.
    int send_idle_pct;
    int recv_stall_pct;

    int error_count;
    int cycle_count;
    int checked_count;
    int start_count;
    int step_count;
    int overrun_count;
    int phase_count;

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    // Gets one signed axis out of a packed point.  The axes are x, y, z from the
    // low bits up.
    function automatic longint lane(input logic [3*CW-1:0] p, input int a);
        logic signed [CW-1:0] v;
        v = p[a*CW +: CW];
        return v;
    endfunction

    // Rounds a Q2.32 product back to Q1.16, half up.
    function automatic longint unsigned qround(input longint unsigned p);
        return (p + HALF) >> TW;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [3*CW-1:0] data);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic rtype, input int tf,
                                           input int x, input int y, input int z);
        plan_row_t r;
        r       = '0;
        r.rtype = rtype;
        r.tf    = tf[TW:0];
        r.x     = x[CW-1:0];
        r.y     = y[CW-1:0];
        r.z     = z[CW-1:0];
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic rtype, input int tf,
                                            input int x, input int y, input int z,
                                            input int wx, input int wy, input int wz);
        plan_row_t r;
        r        = item_row(rtype, tf, x, y, z);
        r.typed  = 1'b1;
        r.want.x = wx[CW-1:0];
        r.want.y = wy[CW-1:0];
        r.want.z = wz[CW-1:0];
        return r;
    endfunction

    // The opening plan.  Positions are typed in only where they are obvious: the
    // current position comes back on a start, t = 0 adds no offset, and at t = 1
    // the offset is the end point.
    localparam int PLAN_ROWS = 31;
    plan_row_t opening_plan [PLAN_ROWS] = '{
        // Step before any start, in the default stack mode.  The start drifts to
        // the current position and the offset is still zero.
        typed_row(REQ_STEP, ONE / 2, 16, -32, 48, 16, -32, 48),
        cfg_row(REG_CONTROL_ONE, PTS_MAX),
        cfg_row(REG_CONTROL_TWO, PTS_MAX),
        cfg_row(REG_END_POINT, PTS_MAX),
        typed_row(REQ_START, 0, 0, 0, 0, 0, 0, 0),
        typed_row(REQ_STEP, 0, 0, 0, 0, 0, 0, 0),
        typed_row(REQ_STEP, ONE, 0, 0, 0, COORD_HI, COORD_HI, COORD_HI),
        // A time fraction past one counts as one.
        typed_row(REQ_STEP, T_WRAP, COORD_HI, COORD_HI, COORD_HI,
                  COORD_HI, COORD_HI, COORD_HI),
        item_row(REQ_STEP, ONE / 2, COORD_HI, COORD_HI, COORD_HI),
        cfg_row(REG_CONTROL_ONE, PTS_MIN),
        cfg_row(REG_CONTROL_TWO, PTS_MIN),
        cfg_row(REG_END_POINT, PTS_MIN),
        typed_row(REQ_START, 0, COORD_LO, COORD_LO, COORD_LO,
                  COORD_LO, COORD_LO, COORD_LO),
        // Start plus offset goes below the range and saturates at the bottom.
        typed_row(REQ_STEP, ONE, COORD_LO, COORD_LO, COORD_LO,
                  COORD_LO, COORD_LO, COORD_LO),
        item_row(REQ_STEP, 1, COORD_LO, COORD_LO, COORD_LO),
        item_row(REQ_STEP, ONE - 1, COORD_LO, COORD_LO, COORD_LO),
        // Absolute mode with the first control point far from the start, so its
        // relative point saturates when it is loaded.
        cfg_row(REG_ABSOLUTE, 1),
        cfg_row(REG_CONTROL_ONE, PTS_MAX),
        typed_row(REQ_START, 0, COORD_LO, COORD_LO, COORD_LO,
                  COORD_LO, COORD_LO, COORD_LO),
        item_row(REQ_STEP, 21845, COORD_LO, COORD_LO, COORD_LO),
        // The object was moved from outside, so the start drifts and saturates.
        item_row(REQ_STEP, 40000, COORD_HI, 0, COORD_LO),
        // Plain mode: z passes through and the previous output stays put.
        cfg_row(REG_STACK, 0),
        item_row(REQ_STEP, 30000, 100, -100, 12345),
        item_row(REQ_START, 0, 1234, -4321, 777),
        item_row(REQ_STEP, 50000, 0, 0, -1),
        cfg_row(REG_SPARE_FIRST, PTS_MAX),
        cfg_row(REG_SPARE_LAST, '1),
        item_row(REQ_STEP, ONE, 5, 5, 5),
        cfg_row(REG_ABSOLUTE, 0),
        item_row(REQ_START, 0, -1, -1, -1),
        item_row(REQ_STEP, ONE + ONE / 2, 3, -3, 9)
    };

    task automatic reset_predictor();
        reg_one  = '0;
        reg_two  = '0;
        reg_end  = '0;
        abs_on   = 1'b0;
        stack_on = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            anchor_pos[a] = 0;
            last_out[a]   = 0;
        end
        for (int k = 0; k < 9; k++)
            curve_pts[k] = 0;
        last_result = '0;
    endtask

    // Works out the position for one request and moves the path state on.
    task automatic advance_path(input plan_row_t it, output pos_t res);
        longint          cur [3];
        longint          r [3];
        longint          s;
        longint          sum;
        longint          off;
        longint          w1;
        longint          w2;
        longint          w3;
        longint unsigned t;
        longint unsigned u;
        longint unsigned tt;
        longint unsigned uu;
        cur[0] = it.x;
        cur[1] = it.y;
        cur[2] = it.z;
        if (it.rtype == REQ_START)
        begin
            // The start latches the position.  The curve points are loaded here
            // and nowhere else, and they are made relative in absolute mode.
            for (int a = 0; a < 3; a++)
            begin
                s = abs_on ? cur[a] : 0;
                anchor_pos[a]    = cur[a];
                last_out[a]      = cur[a];
                curve_pts[a*3]   = clamp_coord(lane(reg_one, a) - s);
                curve_pts[a*3+1] = clamp_coord(lane(reg_two, a) - s);
                curve_pts[a*3+2] = clamp_coord(lane(reg_end, a) - s);
                r[a] = cur[a];
            end
        end
        else
        begin
            t = it.tf;
            if (t > ONE)
                t = ONE;
            u  = ONE - t;
            tt = qround(t * t);
            uu = qround(u * u);
            w1 = 3 * qround(t * uu);
            w2 = 3 * qround(tt * u);
            w3 = qround(tt * t);
            for (int a = 0; a < 3; a++)
            begin
                sum = w1 * curve_pts[a*3] + w2 * curve_pts[a*3+1] + w3 * curve_pts[a*3+2];
                // An arithmetic shift floors, so adding a half rounds half up.
                off = (sum + HALF) >>> TW;
                if (stack_on)
                begin
                    anchor_pos[a] = clamp_coord(anchor_pos[a] + cur[a] - last_out[a]);
                    r[a] = clamp_coord(anchor_pos[a] + off);
                end
                else
                begin
                    r[a] = (a == 2) ? cur[a] : clamp_coord(anchor_pos[a] + off);
                end
            end
            if (stack_on)
            begin
                for (int a = 0; a < 3; a++)
                    last_out[a] = r[a];
            end
        end
        res.x = r[0][CW-1:0];
        res.y = r[1][CW-1:0];
        res.z = r[2][CW-1:0];
    endtask

    // One write on the register port.  The predictor's copy changes at the same edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [3*CW-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            REG_CONTROL_ONE: reg_one  = data;
            REG_CONTROL_TWO: reg_two  = data;
            REG_END_POINT:   reg_end  = data;
            REG_ABSOLUTE:    abs_on   = data[0];
            REG_STACK:       stack_on = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drops the request line and waits until every expected position has
    // arrived.  After that the block is idle and its registers may be written.
    task automatic await_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
    endtask

    // Sends one request.  It returns at the edge where the transfer happens, with
    // valid still high.  The next call or await_idle then decides at the next
    // falling edge whether the line stays busy.
    task automatic send_item(input plan_row_t it);
        pos_t guess;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.req_type  = it.rtype;
        req_ch.time_frac = it.tf;
        req_ch.cur_x     = it.x;
        req_ch.cur_y     = it.y;
        req_ch.cur_z     = it.z;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        advance_path(it, guess);
        last_result = guess;
        expected_positions.push_back(it.typed ? it.want : guess);
        if (it.rtype == REQ_START)
            start_count++;
        else
        begin
            step_count++;
            if (it.tf > ONE)
                overrun_count++;
        end
    endtask

    // A coordinate from the full range, from near the origin, or from the edges.
    function automatic int pick_coord();
        int style;
        style = $urandom_range(0, 9);
        if (style < 4)
            return int'($urandom_range(0, 65535)) + COORD_LO;
        if (style < 8)
            return int'($urandom_range(0, 3000)) - 1500;
        case ($urandom_range(0, 3))
            0: return COORD_HI;
            1: return COORD_LO;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [3*CW-1:0] pick_point();
        int x;
        int y;
        int z;
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    // The object's position on the next step.  Mostly it stays where the block
    // put it.  Sometimes it is moved a little from outside, and now and then it
    // jumps somewhere else.
    function automatic int trailing_coord(input int c);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return c;
        if (roll < 95)
            return int'(clamp_coord(c + int'($urandom_range(0, 600)) - 300));
        return pick_coord();
    endfunction

    // Writes every register for a phase and sets the idle rates.  The phases go
    // through all four mode pairs, through points at both extremes, and through
    // no idling, idling on either side, and idling on both sides.
    task automatic set_up_phase(input int p);
        logic [3*CW-1:0] p_one;
        logic [3*CW-1:0] p_two;
        logic [3*CW-1:0] p_end;
        logic [3*CW-2:0] filler;
        case (p % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default:
            begin
                send_idle_pct  = 35;
                recv_stall_pct = 35;
            end
        endcase
        p_one = pick_point();
        p_two = pick_point();
        p_end = pick_point();
        if (p == 2)
        begin
            p_one = PTS_MAX;
            p_two = PTS_MAX;
            p_end = PTS_MAX;
        end
        else if (p == 6)
        begin
            p_one = PTS_MIN;
            p_two = PTS_MIN;
            p_end = PTS_MIN;
        end
        else if (p == 3)
        begin
            p_one = PTS_MAX;
            p_two = PTS_MIN;
        end
        await_idle();
        write_register(REG_CONTROL_ONE, p_one);
        write_register(REG_CONTROL_TWO, p_two);
        write_register(REG_END_POINT, p_end);
        // Only bit zero of a mode register counts.  The rest gets random filler.
        filler = (3*CW-1)'(pick_point());
        write_register(REG_ABSOLUTE, {filler, p >= 4 ? 1'b1 : 1'b0});
        filler = (3*CW-1)'(pick_point());
        write_register(REG_STACK, {filler, (p % 3) != 1 ? 1'b1 : 1'b0});
        write_register(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), pick_point());
        phase_count++;
    endtask

    // Random paths.  Most of them are a start followed by a sweep of t from zero
    // to one with small jitter.  The rest are single requests with random type, t
    // and position, and about half of those have t past one.
    task automatic run_random_phase(input int quota);
        plan_row_t it;
        int        sent;
        int        steps;
        int        tf;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                it = item_row(REQ_START, 0, pick_coord(), pick_coord(), pick_coord());
                send_item(it);
                sent++;
                steps = $urandom_range(3, 12);
                for (int k = 1; k <= steps; k++)
                begin
                    tf = (k * ONE) / steps;
                    if (k < steps)
                        tf = tf + int'($urandom_range(0, 400)) - 200;
                    if (tf < 0)
                        tf = 0;
                    if (tf > ONE)
                        tf = ONE;
                    it = item_row(REQ_STEP, tf, trailing_coord(last_result.x),
                                  trailing_coord(last_result.y),
                                  trailing_coord(last_result.z));
                    send_item(it);
                    sent++;
                end
            end
            else
            begin
                it = item_row(1'($urandom_range(0, 1)), int'($urandom_range(0, T_WRAP)),
                              pick_coord(), pick_coord(), pick_coord());
                send_item(it);
                sent++;
            end
        end
    endtask

    // Position checker.  Each position transfer is compared with the oldest
    // expectation.  The first few errors are shown and the rest are only counted.
    always @(posedge clk)
    begin
        pos_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_positions.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("%0t: position (%0d, %0d, %0d) with nothing expected",
                             $realtime, rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z);
            end
            else
            begin
                want = expected_positions.pop_front();
                checked_count++;
                if (rsp_ch.pos_x !== want.x || rsp_ch.pos_y !== want.y ||
                    rsp_ch.pos_z !== want.z)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("%0t: position #%0d expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                 $realtime, checked_count, want.x, want.y, want.z,
                                 rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z);
                end
            end
        end
    end

    // The receiver stalls at random.  The rate is set by the running phase.
    always @(negedge clk)
        rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog for a block that hangs or loses a position.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d positions outstanding",
                     cycle_count, expected_positions.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_START;
        req_ch.time_frac = '0;
        req_ch.cur_x     = '0;
        req_ch.cur_y     = '0;
        req_ch.cur_z     = '0;
        rsp_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        error_count      = 0;
        cycle_count      = 0;
        checked_count    = 0;
        start_count      = 0;
        step_count       = 0;
        overrun_count    = 0;
        phase_count      = 0;
        reset_predictor();

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening plan, with no idling.  Registers are written only after the
        // block has handed back every position.
        foreach (opening_plan[i])
        begin
            if (opening_plan[i].is_cfg)
            begin
                await_idle();
                write_register(opening_plan[i].idx, opening_plan[i].data);
            end
            else
                send_item(opening_plan[i]);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_up_phase(p);
            run_random_phase(PHASE_QUOTA);
        end

        await_idle();
        repeat (LATE_CYCLES)
            @(posedge clk);

        if (expected_positions.size() != 0)
        begin
            $display("%0d expected positions never arrived", expected_positions.size());
            error_count += expected_positions.size();
        end
        $display("Ran %0d starts and %0d steps (%0d with t past one) over %0d register phases.",
                 start_count, step_count, overrun_count, phase_count);
        $display("Checked %0d positions in %0d cycles, %0d errors.",
                 checked_count, cycle_count, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
